>>> hdl/rgbm_pkg.sv
`timescale 1ns / 1ps

package rgbm_pkg;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_RESET_HOLD  = 3'd0,
    PH_BANK0_SHIFT = 3'd1,
    PH_BANK0_LATCH = 3'd2,
    PH_ROW_SHIFT   = 3'd3,
    PH_GAP         = 3'd4,
    PH_ROW_LATCH   = 3'd5,
    PH_DWELL       = 3'd6
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] CFG_HALF_PERIOD = 3'd0;
  localparam logic [2:0] CFG_LATCH_GAP   = 3'd1;
  localparam logic [2:0] CFG_ROW_DWELL   = 3'd2;
  localparam logic [2:0] CFG_RESET_HOLD  = 3'd3;
  localparam logic [2:0] CFG_BANK0_LEVEL = 3'd4;

  // input word kinds carried on s_tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned BANK0_BITS = 6;
  localparam int unsigned BYTE_BITS  = 8;

  // pin levels, lowest bit first: clock, data, latch, bank, reset, rows
  typedef struct packed {
    logic [7:0] row_enables;
    logic       reset_line;
    logic       bank_select;
    logic       latch_line;
    logic       data_line;
    logic       clock_line;
  } pins_t;

  // frame byte write request into the store
  typedef struct packed {
    logic       valid;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

endpackage

>>> hdl/rgbm_frame_store.sv
`timescale 1ns / 1ps

module rgbm_frame_store
  import rgbm_pkg::*;
#(
  parameter int unsigned DEPTH = 192,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  wr_req_t       wr,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rword,
  output logic          busy
);

  logic [7:0]    frame_mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [7:0]    rdata;
  logic          byp_hit;
  logic [7:0]    byp_data;

  // zero-fill sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clearing || (wr.valid && ({24'd0, wr.addr} < 32'(DEPTH)));
    wa = clearing ? clr_cnt : AW'(wr.addr);
    wd = clearing ? 8'd0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem[wa] <= wd;
    end
    rdata    <= frame_mem[raddr];
    byp_data <= wd;
  end

  // write to the address being read in the same cycle wins
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= we && (wa == raddr);
    end
  end

  assign rword = byp_hit ? byp_data : rdata;
  assign busy  = clearing;

endmodule

>>> hdl/rgb_led_matrix_scan_driver.sv
`timescale 1ns / 1ps
// throughput: one word per cycle while the skid stage is empty, set by the single-step
//   pin sequencer and the one frame store read port, which always holds the byte the
//   next data load needs; a word's pin result is registered before it is offered
// reset: configuration, sequencer and pins return to their start values; the frame
//   store then zero-fills all ROWS*LEDS_PER_ROW*3 bytes (192) with s_tready low

module rgb_led_matrix_scan_driver
  import rgbm_pkg::*;
#(
  parameter int unsigned ROWS         = 8,
  parameter int unsigned LEDS_PER_ROW = 8,
  parameter int unsigned BANK0_WORDS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_address[7:0], pixel_value[15:8]
  input  logic        s_tuser,   // command: 0 tick, 1 frame byte write
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // clock_line, data_line, latch_line, bank_select,
                                 // reset_line, row_enables[12:5], zero pad [15:13]
  output logic        m_tlast    // frame_done
);

  localparam int unsigned ROW_BYTES   = LEDS_PER_ROW * 3;
  localparam int unsigned FRAME_BYTES = ROWS * ROW_BYTES;
  localparam int unsigned AW          = $clog2(FRAME_BYTES);
  localparam int unsigned RW          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned MAX_BYTES   = (BANK0_WORDS > ROW_BYTES) ? BANK0_WORDS : ROW_BYTES;
  localparam int unsigned BW          = $clog2(MAX_BYTES + 1);

  // configuration registers
  logic [7:0]  half_period_ticks;
  logic [15:0] latch_gap_ticks;
  logic [23:0] row_dwell_ticks;
  logic [23:0] reset_hold_ticks;
  logic [5:0]  bank0_level;

  // sequencer state
  phase_t        phase, phase_next;
  logic [2:0]    bit_idx, bit_idx_next;
  logic [BW-1:0] byte_idx, byte_idx_next;
  logic [RW-1:0] row_idx, row_idx_next;
  logic [23:0]   delay_cnt, delay_cnt_next;
  pins_t         pins, pins_next;
  logic          done;

  // handshake and output staging
  logic    accept;
  logic    tick;
  logic    busy;
  logic    out_valid;
  pins_t   out_pins;
  logic    out_last;
  logic    skid_valid;
  pins_t   skid_pins;
  logic    skid_last;

  // frame store access
  wr_req_t       wr;
  logic [AW-1:0] raddr;
  logic [7:0]    word;

  // wait bookkeeping
  logic [23:0] half_target;
  logic [23:0] wait_target;
  logic [23:0] cnt_inc;
  logic        expire;
  logic        last_byte;
  logic [7:0]  level_word;
  logic [7:0]  shift_src;

  function automatic logic [AW-1:0] frame_addr(input logic [RW-1:0] r,
                                                input logic [BW-1:0] b);
    int unsigned a;
    a = int'(r) * ROW_BYTES + ROW_BYTES - 1 - int'(b);
    return AW'(a);
  endfunction

  function automatic logic [RW-1:0] row_after(input logic [RW-1:0] r);
    return (r == RW'(ROWS - 1)) ? '0 : r + RW'(1);
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign tick     = accept && (s_tuser == CMD_TICK);
  assign s_tready = !skid_valid && !busy;

  // config writes, only issued while idle; the user is bound to this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= 8'd1;
      latch_gap_ticks   <= 16'd4;
      row_dwell_ticks   <= 24'd5000;
      reset_hold_ticks  <= 24'd1000;
      bank0_level       <= 6'd63;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data[7:0];
        CFG_LATCH_GAP:   latch_gap_ticks   <= cfg_data[15:0];
        CFG_ROW_DWELL:   row_dwell_ticks   <= cfg_data;
        CFG_RESET_HOLD:  reset_hold_ticks  <= cfg_data;
        CFG_BANK0_LEVEL: bank0_level       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // frame store: pixel writes in, prefetched next load byte out
  assign wr.valid = accept && (s_tuser == CMD_WRITE);
  assign wr.addr  = s_tdata[7:0];
  assign wr.data  = s_tdata[15:8];

  rgbm_frame_store #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rword (word),
    .busy  (busy)
  );

  // tick wait: count up, step once the count reaches the target
  always_comb begin
    half_target = (half_period_ticks == 8'd0) ? 24'd1 : {16'd0, half_period_ticks};
    case (phase)
      PH_RESET_HOLD: wait_target = reset_hold_ticks;
      PH_GAP:        wait_target = {8'd0, latch_gap_ticks};
      PH_DWELL:      wait_target = row_dwell_ticks;
      default:       wait_target = half_target;
    endcase
    cnt_inc   = delay_cnt + 24'd1;
    expire    = cnt_inc >= wait_target;
    last_byte = (phase == PH_BANK0_SHIFT) ? (byte_idx == BW'(BANK0_WORDS - 1))
                                          : (byte_idx == BW'(ROW_BYTES - 1));
    level_word = {2'b00, bank0_level};
    shift_src  = (phase == PH_BANK0_SHIFT) ? level_word : word;
  end

  // next state
  always_comb begin
    phase_next     = phase;
    bit_idx_next   = bit_idx;
    byte_idx_next  = byte_idx;
    row_idx_next   = row_idx;
    delay_cnt_next = delay_cnt;
    if (tick) begin
      delay_cnt_next = expire ? 24'd0 : cnt_inc;
      unique case (phase)
        PH_RESET_HOLD: begin
          if (expire) begin
            phase_next    = PH_BANK0_SHIFT;
            byte_idx_next = '0;
            bit_idx_next  = 3'(BANK0_BITS - 1);
          end
        end
        PH_BANK0_SHIFT, PH_ROW_SHIFT: begin
          // a bit ends as the clock falls
          if (expire && pins.clock_line) begin
            if (bit_idx != 3'd0) begin
              bit_idx_next = bit_idx - 3'd1;
            end else if (!last_byte) begin
              byte_idx_next = byte_idx + BW'(1);
              bit_idx_next  = (phase == PH_BANK0_SHIFT) ? 3'(BANK0_BITS - 1)
                                                         : 3'(BYTE_BITS - 1);
            end else begin
              byte_idx_next = '0;
              phase_next    = (phase == PH_BANK0_SHIFT) ? PH_BANK0_LATCH : PH_GAP;
            end
          end
        end
        PH_BANK0_LATCH: begin
          if (expire) begin
            row_idx_next  = '0;
            phase_next    = PH_ROW_SHIFT;
            byte_idx_next = '0;
            bit_idx_next  = 3'(BYTE_BITS - 1);
          end
        end
        PH_GAP: begin
          if (expire) begin
            phase_next = PH_ROW_LATCH;
          end
        end
        PH_ROW_LATCH: begin
          if (expire) begin
            phase_next = PH_DWELL;
          end
        end
        PH_DWELL: begin
          if (expire) begin
            row_idx_next  = row_after(row_idx);
            phase_next    = PH_ROW_SHIFT;
            byte_idx_next = '0;
            bit_idx_next  = 3'(BYTE_BITS - 1);
          end
        end
        default: begin
          phase_next     = PH_RESET_HOLD;
          delay_cnt_next = 24'd0;
        end
      endcase
    end
  end

  // pin outputs
  always_comb begin
    pins_next = pins;
    done      = 1'b0;
    if (tick) begin
      unique case (phase)
        PH_RESET_HOLD: begin
          if (expire) begin
            pins_next.reset_line  = 1'b1;
            pins_next.bank_select = 1'b0;
            pins_next.clock_line  = 1'b0;
            pins_next.data_line   = level_word[BANK0_BITS-1];
          end
        end
        PH_BANK0_SHIFT, PH_ROW_SHIFT: begin
          if (expire) begin
            if (!pins.clock_line) begin
              pins_next.clock_line = 1'b1;
            end else begin
              pins_next.clock_line = 1'b0;
              if (bit_idx != 3'd0 || !last_byte) begin
                // next bit goes out as the clock falls
                pins_next.data_line = shift_src[bit_idx_next];
              end else if (phase == PH_BANK0_SHIFT) begin
                pins_next.latch_line = 1'b0;
              end else begin
                pins_next.row_enables = 8'd0;
              end
            end
          end
        end
        PH_BANK0_LATCH: begin
          if (expire) begin
            pins_next.latch_line  = 1'b1;
            pins_next.bank_select = 1'b1;
            pins_next.clock_line  = 1'b0;
            pins_next.data_line   = word[BYTE_BITS-1];
          end
        end
        PH_GAP: begin
          if (expire) begin
            pins_next.latch_line = 1'b0;
          end
        end
        PH_ROW_LATCH: begin
          if (expire) begin
            pins_next.latch_line  = 1'b1;
            // rows past the eighth have no enable pin
            pins_next.row_enables = 8'd1 << row_idx;
          end
        end
        PH_DWELL: begin
          if (expire) begin
            done                  = (row_idx == RW'(ROWS - 1));
            pins_next.bank_select = 1'b1;
            pins_next.clock_line  = 1'b0;
            pins_next.data_line   = word[BYTE_BITS-1];
          end
        end
        default: begin
          pins_next             = '0;
          pins_next.latch_line  = 1'b1;
          pins_next.bank_select = 1'b1;
        end
      endcase
    end
  end

  // address of the byte the next data load will take, from the state after this edge;
  // the store keeps that byte current through later writes
  always_comb begin
    case (phase_next) inside
      PH_ROW_SHIFT: begin
        if (bit_idx_next != 3'd0) begin
          raddr = frame_addr(row_idx_next, byte_idx_next);
        end else if (byte_idx_next == BW'(ROW_BYTES - 1)) begin
          raddr = frame_addr(row_after(row_idx_next), '0);
        end else begin
          raddr = frame_addr(row_idx_next, byte_idx_next + BW'(1));
        end
      end
      PH_GAP, PH_ROW_LATCH, PH_DWELL: raddr = frame_addr(row_after(row_idx_next), '0);
      default:                        raddr = frame_addr('0, '0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RESET_HOLD;
      bit_idx   <= 3'd0;
      byte_idx  <= '0;
      row_idx   <= '0;
      delay_cnt <= 24'd0;
      pins      <= '{row_enables: 8'd0, reset_line: 1'b0, bank_select: 1'b1,
                     latch_line: 1'b1, data_line: 1'b0, clock_line: 1'b0};
    end else begin
      phase     <= phase_next;
      bit_idx   <= bit_idx_next;
      byte_idx  <= byte_idx_next;
      row_idx   <= row_idx_next;
      delay_cnt <= delay_cnt_next;
      pins      <= pins_next;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (accept) begin
        skid_pins <= pins_next;
        skid_last <= done;
      end
    end else if (skid_valid) begin
      out_pins <= skid_pins;
      out_last <= skid_last;
    end else if (accept) begin
      out_pins <= pins_next;
      out_last <= done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_pins};
  assign m_tlast  = out_last;

endmodule

>>> hdl/rgbm_checker.sv
`timescale 1ns / 1ps

module rgbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // store zero-fill holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // at most one row lit
  a_rows_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[12:5]))
    else $error("more than one row enabled");

  // a lit row implies driver out of reset and latch idle high
  a_rows_lit_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[12:5] != 8'd0) |-> m_tdata[2] && m_tdata[4])
    else $error("row lit while latch low or driver in reset");

  // frame end starts a new row shift: bank1 selected, clock low
  a_frame_end_shift: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[3] && !m_tdata[0])
    else $error("frame end without row shift start");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

endmodule

bind rgb_led_matrix_scan_driver rgbm_checker u_checker (.*);

>>> test/rgb_led_matrix_scan_driver_test.sv
`timescale 1ns / 1ps

module rgb_led_matrix_scan_driver_test;
  import rgbm_pkg::*;

  // frame geometry of the instance under test
  localparam int unsigned MATRIX_ROWS  = 8;
  localparam int unsigned ROW_LEDS     = 8;
  localparam int unsigned ROW_BYTES    = ROW_LEDS * 3;
  localparam int unsigned FRAME_BYTES  = MATRIX_ROWS * ROW_BYTES;
  localparam int unsigned START_WORDS  = 24;

  // cycles without any accepted word before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // random back-pressure and sender gaps while set
  bit          idling;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // ---------------------------------------------------------------------------
  // pin sequencer predictor and store of expected pin words
  // ---------------------------------------------------------------------------
  class pin_scoreboard;
    // register copies
    logic [7:0]  half_cfg;
    logic [15:0] gap_cfg;
    logic [23:0] dwell_cfg;
    logic [23:0] hold_cfg;
    logic [5:0]  level_cfg;

    // sequencer copy
    logic [7:0]  frame [FRAME_BYTES];
    phase_t      ph;
    int unsigned bit_idx;
    int unsigned byte_idx;
    int unsigned row_idx;
    logic [23:0] tick_count;
    pins_t       pins;

    pins_t       pending_pins [$];
    bit          pending_done [$];
    int unsigned failures;

    function new();
      half_cfg   = 8'd1;
      gap_cfg    = 16'd4;
      dwell_cfg  = 24'd5000;
      hold_cfg   = 24'd1000;
      level_cfg  = 6'd63;
      foreach (frame[i]) frame[i] = 8'h00;
      ph         = PH_RESET_HOLD;
      bit_idx    = 0;
      byte_idx   = 0;
      row_idx    = 0;
      tick_count = '0;
      pins       = '0;
      pins.latch_line  = 1'b1;
      pins.bank_select = 1'b1;
      failures   = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [23:0] val);
      case (idx)
        CFG_HALF_PERIOD: half_cfg  = val[7:0];
        CFG_LATCH_GAP:   gap_cfg   = val[15:0];
        CFG_ROW_DWELL:   dwell_cfg = val;
        CFG_RESET_HOLD:  hold_cfg  = val;
        CFG_BANK0_LEVEL: level_cfg = val[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned half_ticks();
      return (half_cfg == 8'd0) ? 1 : half_cfg;
    endfunction

    // one tick of a wait; the count wraps at 24 bits
    function bit wait_done(int unsigned target);
      tick_count = tick_count + 24'd1;
      if (tick_count >= target) begin
        tick_count = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // byte being shifted: bank0 level, or leds high to low as b, g, r
    function logic [7:0] shift_byte();
      int unsigned led;
      int unsigned chan;
      if (ph == PH_BANK0_SHIFT) return {2'b00, level_cfg};
      led  = ROW_LEDS - 1 - byte_idx / 3;
      chan = 2 - byte_idx % 3;
      return frame[row_idx * ROW_BYTES + led * 3 + chan];
    endfunction

    function void load_data();
      logic [7:0] b;
      b = shift_byte();
      pins.data_line = b[bit_idx];
    endfunction

    function void start_shift(phase_t p);
      ph         = p;
      byte_idx   = 0;
      bit_idx    = (p == PH_BANK0_SHIFT) ? BANK0_BITS - 1 : BYTE_BITS - 1;
      tick_count = '0;
      pins.bank_select = (p != PH_BANK0_SHIFT);
      pins.clock_line  = 1'b0;
      load_data();
    endfunction

    function void shift_step();
      int unsigned words;
      words = (ph == PH_BANK0_SHIFT) ? START_WORDS : ROW_BYTES;
      if (!wait_done(half_ticks())) return;
      if (!pins.clock_line) begin
        pins.clock_line = 1'b1;
        return;
      end
      // falling clock edge: next bit, next byte, or end of the shift
      pins.clock_line = 1'b0;
      if (bit_idx > 0) begin
        bit_idx--;
        load_data();
        return;
      end
      byte_idx++;
      if (byte_idx < words) begin
        bit_idx = (ph == PH_BANK0_SHIFT) ? BANK0_BITS - 1 : BYTE_BITS - 1;
        load_data();
        return;
      end
      byte_idx = 0;
      if (ph == PH_BANK0_SHIFT) begin
        ph = PH_BANK0_LATCH;
        pins.latch_line = 1'b0;
      end else begin
        ph = PH_GAP;
        pins.row_enables = '0;
      end
    endfunction

    function bit advance_tick();
      bit done;
      done = 1'b0;
      case (ph)
        PH_RESET_HOLD: begin
          if (wait_done(hold_cfg)) begin
            pins.reset_line = 1'b1;
            start_shift(PH_BANK0_SHIFT);
          end
        end
        PH_BANK0_SHIFT, PH_ROW_SHIFT: shift_step();
        PH_BANK0_LATCH: begin
          if (wait_done(half_ticks())) begin
            pins.latch_line = 1'b1;
            row_idx = 0;
            start_shift(PH_ROW_SHIFT);
          end
        end
        PH_GAP: begin
          if (wait_done(gap_cfg)) begin
            pins.latch_line = 1'b0;
            ph = PH_ROW_LATCH;
          end
        end
        PH_ROW_LATCH: begin
          if (wait_done(half_ticks())) begin
            pins.latch_line  = 1'b1;
            pins.row_enables = 8'd1 << row_idx;
            ph = PH_DWELL;
          end
        end
        PH_DWELL: begin
          if (wait_done(dwell_cfg)) begin
            done    = (row_idx == MATRIX_ROWS - 1);
            row_idx = (row_idx + 1) % MATRIX_ROWS;
            start_shift(PH_ROW_SHIFT);
          end
        end
        default: begin
          ph         = PH_RESET_HOLD;
          tick_count = '0;
          pins       = '0;
          pins.latch_line  = 1'b1;
          pins.bank_select = 1'b1;
        end
      endcase
      return done;
    endfunction

    function void note_word(bit cmd, logic [7:0] addr, logic [7:0] val);
      bit done;
      done = 1'b0;
      if (cmd == CMD_WRITE) begin
        if (addr < FRAME_BYTES) frame[addr] = val;
      end else begin
        done = advance_tick();
      end
      pending_pins.push_back(pins);
      pending_done.push_back(done);
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      failures++;
      if (failures <= 10)
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    endfunction

    function void check_result(logic [15:0] word, logic last);
      pins_t want;
      pins_t got;
      bit    want_done;
      if (pending_pins.size() == 0) begin
        flag("unexpected word", 16'h0, word);
        return;
      end
      want      = pending_pins.pop_front();
      want_done = pending_done.pop_front();
      got       = word[12:0];
      if (got.clock_line !== want.clock_line)
        flag("clock_line", 16'(want.clock_line), 16'(got.clock_line));
      if (got.data_line !== want.data_line)
        flag("data_line", 16'(want.data_line), 16'(got.data_line));
      if (got.latch_line !== want.latch_line)
        flag("latch_line", 16'(want.latch_line), 16'(got.latch_line));
      if (got.bank_select !== want.bank_select)
        flag("bank_select", 16'(want.bank_select), 16'(got.bank_select));
      if (got.reset_line !== want.reset_line)
        flag("reset_line", 16'(want.reset_line), 16'(got.reset_line));
      if (got.row_enables !== want.row_enables)
        flag("row_enables", 16'(want.row_enables), 16'(got.row_enables));
      if (word[15:13] !== 3'b000)
        flag("tdata pad", 16'h0, 16'(word[15:13]));
      if (last !== want_done)
        flag("frame_done", 16'(want_done), 16'(last));
    endfunction
  endclass

  pin_scoreboard sb;

  rgb_led_matrix_scan_driver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stall bursts, checking every accepted word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(1, 3) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // hang detection: counts cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // register write; the caller drops cfg_we after the last one
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_register(idx, val);
    @(posedge clk);
  endtask

  task automatic set_all(logic [7:0] half, logic [15:0] gap, logic [23:0] dwell,
                         logic [23:0] hold, logic [5:0] level);
    write_reg(CFG_HALF_PERIOD, {16'h0, half});
    write_reg(CFG_LATCH_GAP, {8'h0, gap});
    write_reg(CFG_ROW_DWELL, dwell);
    write_reg(CFG_RESET_HOLD, hold);
    write_reg(CFG_BANK0_LEVEL, {18'h0, level});
    cfg_we <= 1'b0;
  endtask

  // offer one input word, with an optional gap first, and note it once accepted
  task automatic send_word(bit cmd, logic [7:0] addr, logic [7:0] val);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {val, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(cmd, addr, val);
  endtask

  // mostly ticks; writes land mostly inside the frame, some beyond it
  task automatic run_random(int unsigned n, int unsigned write_pct);
    logic [7:0] addr;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(FRAME_BYTES, 255))
                                           : 8'($urandom_range(0, FRAME_BYTES - 1));
        send_word(CMD_WRITE, addr, 8'($urandom_range(0, 255)));
      end else begin
        // address and value ride along on ticks and must be ignored
        send_word(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // wait until every expected pin word has come back, plus the output register
  task automatic drain();
    while (sb.pending_pins.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    sb           = new();
    idling       = 1'b1;
    stall_left   = 0;
    quiet_cycles = 0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_TICK;
    m_tready  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // short timings so the scan moves quickly through start-up and rows; zero reset hold
    set_all(8'd1, 16'd0, 24'd0, 24'd0, 6'($urandom_range(0, 63)));

    // directed: frame corners, out-of-range writes, first shifted bytes, ticks
    send_word(CMD_WRITE, 8'd0, 8'hFF);
    send_word(CMD_WRITE, 8'd191, 8'h80);
    send_word(CMD_WRITE, 8'd192, 8'hAA);
    send_word(CMD_WRITE, 8'd255, 8'h55);
    send_word(CMD_WRITE, 8'd23, 8'hA5);
    send_word(CMD_WRITE, 8'd22, 8'h00);
    send_word(CMD_WRITE, 8'd21, 8'h5A);
    send_word(CMD_WRITE, 8'd100, 8'h01);
    for (int i = 0; i < 14; i++) send_word(CMD_TICK, 8'hFF, 8'hFF);
    send_word(CMD_WRITE, 8'd23, 8'h3C);
    send_word(CMD_TICK, 8'h00, 8'h00);
    run_random(500, 10);
    drain();

    // zero half period counts as one tick
    set_all(8'd0, 16'd3, 24'd2, 24'hFFFFFF, 6'd0);
    run_random(500, 10);
    drain();

    // longest gap and dwell targets, no idling here
    idling = 1'b0;
    set_all(8'd2, 16'hFFFF, 24'hFFFFFF, 24'd1000, 6'd63);
    run_random(150, 10);
    drain();

    // longest half period with lowered gap and dwell targets
    idling = 1'b1;
    set_all(8'd255, 16'd1, 24'd5, 24'd0, 6'($urandom_range(0, 63)));
    run_random(150, 10);
    drain();

    // last stretch at full rate on both sides
    idling = 1'b0;
    set_all(8'd1, 16'd1, 24'd1, 24'd1, 6'd63);
    run_random(380, 8);
    drain();
    repeat (4) @(posedge clk);

    if (sb.failures == 0 && sb.pending_pins.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
